FILE: design/fdba_pkg.sv
// Shared types, constants and helper functions for the flash directory allocator.
package fdba_pkg;

    localparam int SLOTS_DEF        = 127;
    localparam int NAME_BYTES_DEF   = 24;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int REGION_SIZE_DEF  = 1048576;
    localparam logic [31:0] REGION_BASE_RST = 32'd271581184;

    localparam int NAME_W  = 192;
    localparam int START_W = 32;
    localparam int LEN_W   = 21;
    localparam int ENTRY_W = NAME_W + START_W + LEN_W;

    // Request modes.
    localparam logic [2:0] MODE_LOOKUP = 3'd0;
    localparam logic [2:0] MODE_STORE  = 3'd1;
    localparam logic [2:0] MODE_REMOVE = 3'd2;
    localparam logic [2:0] MODE_LIST   = 3'd3;
    localparam logic [2:0] MODE_FORMAT = 3'd4;

    // Result codes.
    localparam logic [2:0] RC_DONE      = 3'd0;
    localparam logic [2:0] RC_NOT_FOUND = 3'd1;
    localparam logic [2:0] RC_NO_SPACE  = 3'd2;
    localparam logic [2:0] RC_FULL      = 3'd3;
    localparam logic [2:0] RC_BAD       = 3'd4;

    // One directory entry as held in the slot memory.
    typedef struct packed {
        logic [NAME_W-1:0]  name;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
    } fdba_entry_t;

    // Scan outcome handed from the compare unit to the sequencer.
    typedef struct packed {
        logic       found;
        logic [7:0] idx;
        logic       free_found;
        logic [7:0] free_idx;
    } fdba_hit_t;

    // Keep name bytes below the first zero byte and below limit; clear the rest.
    function automatic logic [NAME_W-1:0] name_norm(input logic [NAME_W-1:0] src,
                                                    input int limit);
        logic [NAME_W-1:0] dst;
        logic              ended;
        dst   = '0;
        ended = 1'b0;
        for (int i = 0; i < 24; i++) begin
            if (i >= limit || src[i*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                dst[i*8 +: 8] = src[i*8 +: 8];
            end
        end
        return dst;
    endfunction

endpackage

FILE: design/fdba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fdba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/fdba_scan.sv
// Shared compare unit: checks one slot per cycle and keeps the scan outcome.
module fdba_scan (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         clear,
    input  logic                         list_mode,
    input  logic [7:0]                   list_index,
    input  logic [fdba_pkg::NAME_W-1:0]  key_name,
    input  logic                         chk_valid,
    input  logic [7:0]                   chk_idx,
    input  logic                         slot_vld,
    input  fdba_pkg::fdba_entry_t        rd_entry,
    output fdba_pkg::fdba_hit_t          hit,
    output fdba_pkg::fdba_entry_t        hit_entry
);

    fdba_pkg::fdba_hit_t   hit_reg, hit_next;
    fdba_pkg::fdba_entry_t hit_entry_reg;
    logic [7:0]            seen_reg, seen_next;
    logic                  match;

    // A slot matches on name, or for list on its rank among valid slots.
    always_comb begin
        if (list_mode) begin
            match = slot_vld && (seen_reg == list_index);
        end else begin
            match = slot_vld && (rd_entry.name == key_name);
        end
    end

    // Keep the first match and the first free slot.
    always_comb begin
        hit_next  = hit_reg;
        seen_next = seen_reg;
        if (clear) begin
            hit_next  = '0;
            seen_next = '0;
        end else if (chk_valid) begin
            if (match && !hit_reg.found) begin
                hit_next.found = 1'b1;
                hit_next.idx   = chk_idx;
            end
            if (!slot_vld && !hit_reg.free_found) begin
                hit_next.free_found = 1'b1;
                hit_next.free_idx   = chk_idx;
            end
            if (slot_vld) begin
                seen_next = seen_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg  <= '0;
            seen_reg <= '0;
        end else begin
            hit_reg  <= hit_next;
            seen_reg <= seen_next;
        end
    end

    // Entry contents of the first match.
    always_ff @(posedge aclk) begin
        if (chk_valid && match && !hit_reg.found) begin
            hit_entry_reg <= rd_entry;
        end
    end

    assign hit       = hit_reg;
    assign hit_entry = hit_entry_reg;

endmodule

FILE: design/flash_directory_bump_allocator_unit.sv
// Top level of the flash directory engine with bump allocation.
// Each request scans every slot, reading one entry per cycle, and its result beat is
// registered in the finish step; format and unknown modes skip the scan and go to it.
// A new request is taken only once the engine is idle again after the finish step; a
// result beat that is not taken holds the finish step.
// Reset: aresetn clears the valid bits and count and resets the base and bump pointer at once; no clearing pass.
module flash_directory_bump_allocator_unit #(
    parameter int SLOTS        = fdba_pkg::SLOTS_DEF,
    parameter int NAME_BYTES   = fdba_pkg::NAME_BYTES_DEF,
    parameter int SECTOR_BYTES = fdba_pkg::SECTOR_BYTES_DEF,
    parameter int REGION_SIZE  = fdba_pkg::REGION_SIZE_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode[2:0], name_bytes_lo[66:3], name_bytes_mid[130:67], name_bytes_hi[194:131],
    // byte_count[215:195], list_index[223:216]
    input  logic [223:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // result_code[2:0], entry_start[34:3], entry_length[55:35], out_name_lo[119:56],
    // out_name_mid[183:120], out_name_hi[247:184], bytes in use[268:248],
    // file_count[275:269], zero[279:276]
    output logic [279:0] m_tdata
);

    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [31:0] region_base_reg;
    logic [31:0] next_free_reg, next_free_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [SLOTS-1:0] vld_reg, vld_next;

    // Registered request.
    logic [2:0]                 mode_reg;
    logic [fdba_pkg::NAME_W-1:0] key_reg, store_name_reg;
    logic [20:0]                count_reg;
    logic [7:0]                 lidx_reg;

    // Scan control.
    logic [AW-1:0] idx_reg, idx_next;
    logic          issue_reg, issue_next;
    logic          chk_v_reg;
    logic [AW-1:0] chk_idx_reg;
    logic          s_acc, out_free;

    // Memory and compare unit.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    fdba_pkg::fdba_entry_t ram_wdata, ram_rdata, hit_entry;
    fdba_pkg::fdba_hit_t   hit;

    // Result register.
    logic         m_tvalid_reg, m_tvalid_next;
    logic [279:0] m_tdata_reg, m_tdata_next;

    // Finish-step arithmetic.
    logic [21:0]   reserved;
    logic [31:0]   used32;
    logic [32:0]   need;
    logic [2:0]    rc;
    logic [31:0]   o_start;
    logic [20:0]   o_len;
    logic [fdba_pkg::NAME_W-1:0] o_name;
    logic [7:0]    sel_slot;
    logic [31:0]   used_new;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Capture the request and the two normalized forms of its name.
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            mode_reg       <= s_tdata[2:0];
            key_reg        <= fdba_pkg::name_norm(s_tdata[194:3], NAME_BYTES);
            store_name_reg <= fdba_pkg::name_norm(s_tdata[194:3], NAME_BYTES - 1);
            count_reg      <= s_tdata[215:195];
            lidx_reg       <= s_tdata[223:216];
        end
    end

    // Slot memory holding name, start and length.
    fdba_ram #(
        .WIDTH(fdba_pkg::ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    fdba_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (s_acc),
        .list_mode (mode_reg == fdba_pkg::MODE_LIST),
        .list_index(lidx_reg),
        .key_name  (key_reg),
        .chk_valid (chk_v_reg),
        .chk_idx   (8'(chk_idx_reg)),
        .slot_vld  (vld_reg[chk_idx_reg]),
        .rd_entry  (ram_rdata),
        .hit       (hit),
        .hit_entry (hit_entry)
    );

    // Space check: size rounded up to whole sectors against what is left.
    assign reserved = (22'(count_reg) + 22'(SECTOR_BYTES - 1)) & ~22'(SECTOR_BYTES - 1);
    assign used32   = next_free_reg - region_base_reg;
    assign need     = {1'b0, used32} + 33'(reserved);
    assign sel_slot = hit.found ? hit.idx : hit.free_idx;

    // Sequencer and the state update at the end of each request.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        next_free_next = next_free_reg;
        live_next      = live_reg;
        vld_next       = vld_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        ram_we         = 1'b0;
        ram_waddr      = sel_slot[AW-1:0];
        ram_wdata      = '{name: store_name_reg, start: next_free_reg, length: count_reg};
        rc             = fdba_pkg::RC_DONE;
        o_start        = '0;
        o_len          = '0;
        o_name         = '0;
        used_new       = '0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    idx_next   = '0;
                    issue_next = 1'b1;
                    if (s_tdata[2:0] inside {fdba_pkg::MODE_LOOKUP, fdba_pkg::MODE_STORE,
                                             fdba_pkg::MODE_REMOVE, fdba_pkg::MODE_LIST}) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    if (idx_reg == AW'(SLOTS - 1)) begin
                        issue_next = 1'b0;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
                if (chk_v_reg && chk_idx_reg == AW'(SLOTS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    case (mode_reg)
                        fdba_pkg::MODE_LOOKUP: begin
                            if (hit.found) begin
                                o_start = hit_entry.start;
                                o_len   = hit_entry.length;
                            end else begin
                                rc = fdba_pkg::RC_NOT_FOUND;
                            end
                        end
                        fdba_pkg::MODE_STORE: begin
                            if (count_reg == '0) begin
                                rc = fdba_pkg::RC_BAD;
                            end else if (need > 33'(REGION_SIZE)) begin
                                rc = fdba_pkg::RC_NO_SPACE;
                            end else if (!hit.found && !hit.free_found) begin
                                rc = fdba_pkg::RC_FULL;
                            end else begin
                                ram_we                  = 1'b1;
                                vld_next[sel_slot[AW-1:0]] = 1'b1;
                                if (!hit.found) begin
                                    live_next = live_reg + CNT_W'(1);
                                end
                                o_start        = next_free_reg;
                                o_len          = count_reg;
                                next_free_next = next_free_reg + 32'(reserved);
                            end
                        end
                        fdba_pkg::MODE_REMOVE: begin
                            if (hit.found) begin
                                o_start                 = hit_entry.start;
                                o_len                   = hit_entry.length;
                                vld_next[hit.idx[AW-1:0]] = 1'b0;
                                if (live_reg != '0) begin
                                    live_next = live_reg - CNT_W'(1);
                                end
                            end else begin
                                rc = fdba_pkg::RC_NOT_FOUND;
                            end
                        end
                        fdba_pkg::MODE_LIST: begin
                            if (hit.found) begin
                                o_start = hit_entry.start;
                                o_len   = hit_entry.length;
                                o_name  = hit_entry.name;
                            end else begin
                                rc = fdba_pkg::RC_NOT_FOUND;
                            end
                        end
                        fdba_pkg::MODE_FORMAT: begin
                            vld_next       = '0;
                            live_next      = '0;
                            next_free_next = region_base_reg + 32'(SECTOR_BYTES);
                        end
                        default: begin
                            rc = fdba_pkg::RC_BAD;
                        end
                    endcase
                    used_new      = next_free_next - region_base_reg;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'd0, 7'(live_next), used_new[20:0], o_name,
                                     o_len, o_start, rc};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A base write formats the directory against the new base.
        if (cfg_we) begin
            vld_next       = '0;
            live_next      = '0;
            next_free_next = cfg_wdata + 32'(SECTOR_BYTES);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            region_base_reg <= fdba_pkg::REGION_BASE_RST;
            next_free_reg   <= fdba_pkg::REGION_BASE_RST + 32'(SECTOR_BYTES);
            live_reg        <= '0;
            vld_reg         <= '0;
            issue_reg       <= 1'b0;
            chk_v_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            live_reg      <= live_next;
            vld_reg       <= vld_next;
            issue_reg     <= issue_next;
            chk_v_reg     <= (state_reg == ST_SCAN) && issue_reg;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we) begin
                region_base_reg <= cfg_wdata;
            end
        end
    end

    // Scan pointer and result payload.
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        chk_idx_reg <= idx_reg;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: design/fdba_checker.sv
// Port-level checker for the directory engine, bound to the top level.
module fdba_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [279:0] m_tdata
);

    // A pending result beat stays until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // The engine is busy right after it takes a request.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while a request is in work");

    // Result codes stay within the defined set.
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] <= fdba_pkg::RC_BAD)
        else $error("undefined result code");

    // A failed request reports no entry.
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != fdba_pkg::RC_DONE |-> m_tdata[55:3] == '0)
        else $error("failed request reports an entry");

endmodule

bind flash_directory_bump_allocator_unit fdba_checker u_fdba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the flash directory allocator: table-driven and random requests.
module tb_top;

    localparam logic [2:0]  MODE_TOP     = 3'd7;
    localparam int          SECTOR       = fdba_pkg::SECTOR_BYTES_DEF;
    localparam int          REGION       = fdba_pkg::REGION_SIZE_DEF;
    localparam int          NSLOT        = fdba_pkg::SLOTS_DEF;
    localparam int          DRAIN_CYCLES = 200;
    localparam int          POOL_N       = 16;

    // One result beat, in field order.
    typedef struct packed {
        logic [2:0]   code;
        logic [31:0]  start;
        logic [20:0]  length;
        logic [191:0] name;
        logic [20:0]  used;
        logic [6:0]   files;
    } dir_result_t;

    // A predicted result, optionally with a hand-written result code as well.
    typedef struct {
        dir_result_t res;
        bit          fixed;
        logic [2:0]  fixed_code;
    } dir_expect_t;

    // One row of the directed request table.
    typedef struct {
        logic [2:0]   mode;
        logic [191:0] name;
        logic [20:0]  count;
        logic [7:0]   lidx;
        bit           fixed;
        logic [2:0]   code;
    } req_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [223:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [279:0] m_tdata;

    // Shadow copy of the directory.
    logic         dir_valid[NSLOT];
    logic [191:0] dir_name[NSLOT];
    logic [31:0]  dir_start[NSLOT];
    logic [20:0]  dir_length[NSLOT];
    logic [31:0]  dir_base;
    logic [31:0]  dir_next_free;
    int           dir_live;

    dir_expect_t  pending_results[$];
    int           error_count;
    int           mismatch_count;
    int           result_count;
    int           burst_left;
    logic [191:0] name_pool[POOL_N];
    int           pool_len[POOL_N];
    req_row_t     rows[$];

    flash_directory_bump_allocator_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock with a period of two time units.
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Keep bytes below the first zero byte and below the limit.
    function automatic logic [191:0] clip_name(input logic [191:0] raw, input int limit);
        logic [191:0] clean;
        bit           ended;
        clean = '0;
        ended = 1'b0;
        for (int i = 0; i < 24; i++) begin
            if (i >= limit || raw[i*8 +: 8] == 8'd0) begin
                ended = 1'b1;
            end
            if (!ended) begin
                clean[i*8 +: 8] = raw[i*8 +: 8];
            end
        end
        return clean;
    endfunction

    function automatic int lookup_slot(input logic [191:0] key);
        for (int s = 0; s < NSLOT; s++) begin
            if (dir_valid[s] && dir_name[s] == key) begin
                return s;
            end
        end
        return -1;
    endfunction

    function automatic void clear_directory();
        for (int s = 0; s < NSLOT; s++) begin
            dir_valid[s]  = 1'b0;
            dir_name[s]   = '0;
            dir_start[s]  = '0;
            dir_length[s] = '0;
        end
        dir_next_free = dir_base + SECTOR;
        dir_live      = 0;
    endfunction

    // Compute the result of one request and update the shadow directory.
    function automatic dir_result_t predict_request(input logic [2:0] mode,
                                                    input logic [191:0] raw,
                                                    input logic [20:0] count,
                                                    input logic [7:0] lidx);
        dir_result_t  r;
        logic [191:0] key;
        logic [63:0]  reserved;
        logic [63:0]  used;
        logic [31:0]  offset;
        int           s;
        int           seen;
        r      = '0;
        r.code = fdba_pkg::RC_DONE;
        key    = clip_name(raw, fdba_pkg::NAME_BYTES_DEF);
        case (mode)
            fdba_pkg::MODE_LOOKUP: begin
                s = lookup_slot(key);
                if (s < 0) begin
                    r.code = fdba_pkg::RC_NOT_FOUND;
                end else begin
                    r.start  = dir_start[s];
                    r.length = dir_length[s];
                end
            end
            fdba_pkg::MODE_STORE: begin
                reserved = ((64'(count) + SECTOR - 1) / SECTOR) * SECTOR;
                offset   = dir_next_free - dir_base;
                used     = 64'(offset);
                if (count == 0) begin
                    r.code = fdba_pkg::RC_BAD;
                end else if (used + reserved > REGION) begin
                    r.code = fdba_pkg::RC_NO_SPACE;
                end else begin
                    s = lookup_slot(key);
                    if (s < 0) begin
                        for (int k = 0; k < NSLOT; k++) begin
                            if (!dir_valid[k] && s < 0) begin
                                s = k;
                            end
                        end
                        if (s >= 0) begin
                            dir_live++;
                        end
                    end
                    if (s < 0) begin
                        r.code = fdba_pkg::RC_FULL;
                    end else begin
                        dir_valid[s]  = 1'b1;
                        dir_name[s]   = clip_name(key, fdba_pkg::NAME_BYTES_DEF - 1);
                        dir_start[s]  = dir_next_free;
                        dir_length[s] = count;
                        r.start       = dir_next_free;
                        r.length      = count;
                        dir_next_free = dir_next_free + 32'(reserved);
                    end
                end
            end
            fdba_pkg::MODE_REMOVE: begin
                s = lookup_slot(key);
                if (s < 0) begin
                    r.code = fdba_pkg::RC_NOT_FOUND;
                end else begin
                    r.start      = dir_start[s];
                    r.length     = dir_length[s];
                    dir_valid[s] = 1'b0;
                    if (dir_live != 0) begin
                        dir_live--;
                    end
                end
            end
            fdba_pkg::MODE_LIST: begin
                r.code = fdba_pkg::RC_NOT_FOUND;
                seen   = 0;
                for (int k = 0; k < NSLOT; k++) begin
                    if (dir_valid[k] && r.code == fdba_pkg::RC_NOT_FOUND) begin
                        if (seen == int'(lidx)) begin
                            r.code   = fdba_pkg::RC_DONE;
                            r.start  = dir_start[k];
                            r.length = dir_length[k];
                            r.name   = dir_name[k];
                        end
                        seen++;
                    end
                end
            end
            fdba_pkg::MODE_FORMAT: begin
                clear_directory();
            end
            default: begin
                r.code = fdba_pkg::RC_BAD;
            end
        endcase
        offset  = dir_next_free - dir_base;
        r.used  = offset[20:0];
        r.files = 7'(dir_live);
        return r;
    endfunction

    // Random name of the given length; bytes after the terminator may hold junk.
    function automatic logic [191:0] make_name(input int len);
        logic [191:0] n;
        bit           junk;
        n    = '0;
        junk = ($urandom_range(0, 1) == 1);
        for (int i = 0; i < 24; i++) begin
            if (i < len) begin
                n[i*8 +: 8] = 8'($urandom_range(1, 255));
            end else if (i > len && junk) begin
                n[i*8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return n;
    endfunction

    // Re-dress a clean pool name with fresh junk after its terminator.
    function automatic logic [191:0] dress_name(input int idx);
        logic [191:0] n;
        n = name_pool[idx];
        if ($urandom_range(0, 1) == 1) begin
            for (int i = pool_len[idx] + 1; i < 24; i++) begin
                n[i*8 +: 8] = 8'($urandom_range(0, 255));
            end
        end
        return n;
    endfunction

    function automatic req_row_t row(input logic [2:0] mode, input logic [191:0] name,
                                     input logic [20:0] count, input logic [7:0] lidx,
                                     input bit fixed, input logic [2:0] code);
        req_row_t t;
        t.mode  = mode;
        t.name  = name;
        t.count = count;
        t.lidx  = lidx;
        t.fixed = fixed;
        t.code  = code;
        return t;
    endfunction

    // Offer one request beat, after a random gap at the end of each burst.
    task automatic send_request(input logic [2:0] mode, input logic [191:0] name,
                                input logic [20:0] count, input logic [7:0] lidx,
                                input bit fixed, input logic [2:0] code);
        dir_expect_t e;
        int          gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata  <= {lidx, count, name, mode};
        s_tvalid <= 1'b1;
        forever begin
            @(negedge aclk);
            if (s_tready) begin
                break;
            end
        end
        e.res        = predict_request(mode, name, count, lidx);
        e.fixed      = fixed;
        e.fixed_code = code;
        pending_results.push_back(e);
        @(posedge aclk);
    endtask

    // Let the block drain, then write the region base.
    task automatic write_region_base(input logic [31:0] base);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wdata <= base;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        dir_base  = base;
        clear_directory();
    endtask

    task automatic random_request();
        int           r;
        logic [2:0]   mode;
        logic [191:0] name;
        logic [20:0]  count;
        logic [7:0]   lidx;
        r = $urandom_range(0, 99);
        if (r < 38) begin
            mode = fdba_pkg::MODE_STORE;
        end else if (r < 58) begin
            mode = fdba_pkg::MODE_LOOKUP;
        end else if (r < 72) begin
            mode = fdba_pkg::MODE_REMOVE;
        end else if (r < 90) begin
            mode = fdba_pkg::MODE_LIST;
        end else if (r < 94) begin
            mode = fdba_pkg::MODE_FORMAT;
        end else begin
            mode = 3'($urandom_range(int'(fdba_pkg::MODE_FORMAT) + 1, int'(MODE_TOP)));
        end
        if ($urandom_range(0, 9) == 0) begin
            name = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            name = dress_name($urandom_range(0, POOL_N - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            count = 21'($urandom_range(1, 12000));
        end else if (r < 80) begin
            count = 21'($urandom_range(1, 8) * SECTOR);
        end else if (r < 94) begin
            count = 21'($urandom_range(1, REGION));
        end else if (r < 97) begin
            count = '0;
        end else begin
            count = 21'(REGION);
        end
        lidx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 15))
                                           : 8'($urandom_range(0, 255));
        send_request(mode, name, count, lidx, 1'b0, fdba_pkg::RC_DONE);
    endtask

    // Fill the directory past its last slot, then churn it.
    task automatic fill_directory();
        logic [191:0] n;
        send_request(fdba_pkg::MODE_FORMAT, '0, '0, '0, 1'b1, fdba_pkg::RC_DONE);
        for (int i = 0; i < NSLOT + 3; i++) begin
            n = make_name($urandom_range(2, 23));
            n[7:0]  = 8'h46;
            n[15:8] = 8'(i + 1);
            send_request(fdba_pkg::MODE_STORE, n, 21'($urandom_range(1, SECTOR)), '0, 1'b0,
                         fdba_pkg::RC_DONE);
        end
        for (int i = 0; i < 30; i++) begin
            random_request();
        end
    endtask

    // Compare one field and report the first few mismatches.
    task automatic check_field(input string label, input logic [191:0] want,
                               input logic [191:0] got);
        if (want !== got) begin
            error_count++;
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("result %0d: %s expected %h got %h", result_count, label, want, got);
            end
        end
    endtask

    // Result checker: sample completed beats away from the driving edge.
    always @(negedge aclk) begin
        dir_expect_t e;
        dir_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[2:0], m_tdata[34:3], m_tdata[55:35], m_tdata[247:56],
                   m_tdata[268:248], m_tdata[275:269]};
            if (pending_results.size() == 0) begin
                error_count++;
                $display("result %0d: no request waiting for this beat", result_count);
            end else begin
                e = pending_results.pop_front();
                check_field("result_code", 192'(e.res.code), 192'(got.code));
                check_field("entry_start", 192'(e.res.start), 192'(got.start));
                check_field("entry_length", 192'(e.res.length), 192'(got.length));
                check_field("out_name", e.res.name, got.name);
                check_field("bytes in use", 192'(e.res.used), 192'(got.used));
                check_field("file_count", 192'(e.res.files), 192'(got.files));
                check_field("pad", '0, 192'(m_tdata[279:276]));
                if (e.fixed) begin
                    check_field("table result_code", 192'(e.fixed_code), 192'(got.code));
                end
            end
            result_count++;
        end
    end

    // Receiver: stretches of steady and random readiness, plus one long hold-off.
    initial begin
        int  left;
        int  pct;
        bit  held;
        m_tready = 1'b0;
        left     = 0;
        pct      = 100;
        held     = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && result_count >= 100) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (3000) @(posedge aclk);
            end else begin
                if (left == 0) begin
                    left = $urandom_range(20, 400);
                    pct  = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(5, 90);
                end
                left--;
                m_tready <= ($urandom_range(1, 100) <= pct);
            end
        end
    end

    // Run limit.
    initial begin
        #2000000;
        $display("[flash_directory_bump_allocator_unit] ERROR");
        $finish;
    end

    // Stimulus.
    initial begin
        logic [191:0] full_name;
        logic [191:0] cut_name;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        error_count    = 0;
        mismatch_count = 0;
        result_count   = 0;
        burst_left     = 0;
        dir_base       = fdba_pkg::REGION_BASE_RST;
        clear_directory();
        for (int i = 0; i < POOL_N; i++) begin
            pool_len[i]  = (i == 0) ? 0 : (i == 1) ? 24 : (i == 2) ? 23 : $urandom_range(1, 24);
            name_pool[i] = clip_name(make_name(pool_len[i]), 24);
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: empty directory, name limits, junk after the
        // terminator, refused sizes, bad modes and running out of space.
        full_name = {24{8'hA5}};
        cut_name  = {8'h00, {23{8'hA5}}};
        rows.push_back(row(fdba_pkg::MODE_LOOKUP, '0, '0, '0, 1'b1, fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_LIST, '0, '0, '0, 1'b1, fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_REMOVE, 192'h41, '0, '0, 1'b1,
                           fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'h41, '0, '0, 1'b1, fdba_pkg::RC_BAD));
        rows.push_back(row(3'd5, 192'h41, 21'd1, '0, 1'b1, fdba_pkg::RC_BAD));
        rows.push_back(row(MODE_TOP, '1, '1, '1, 1'b1, fdba_pkg::RC_BAD));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'h41, 21'd1, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'h41, 21'd4096, '0, 1'b1,
                           fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_STORE, full_name, 21'd4097, '0, 1'b1,
                           fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LOOKUP, full_name, '0, '0, 1'b1,
                           fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_LOOKUP, cut_name, '0, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_STORE, '0, 21'd1, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LOOKUP, '0, '0, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LIST, '0, '0, 8'd0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LIST, '0, '0, 8'd2, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LIST, '0, '0, 8'd3, 1'b1, fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_LIST, '0, '0, 8'd255, 1'b1,
                           fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'h42, 21'(REGION), '0, 1'b1,
                           fdba_pkg::RC_NO_SPACE));
        rows.push_back(row(fdba_pkg::MODE_REMOVE, 192'h41, '0, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LOOKUP, 192'h41, '0, '0, 1'b1,
                           fdba_pkg::RC_NOT_FOUND));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'hDEAD_0042, 21'd8191, '0, 1'b1,
                           fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_LOOKUP, 192'h42, '0, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_FORMAT, '0, '0, '0, 1'b1, fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'h43, 21'(REGION - SECTOR), '0, 1'b1,
                           fdba_pkg::RC_DONE));
        rows.push_back(row(fdba_pkg::MODE_STORE, 192'h44, 21'd1, '0, 1'b1,
                           fdba_pkg::RC_NO_SPACE));
        foreach (rows[i]) begin
            send_request(rows[i].mode, rows[i].name, rows[i].count, rows[i].lidx,
                         rows[i].fixed, rows[i].code);
        end

        // Random phases over several region bases, the extremes among them.
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: write_region_base(32'd4096);
                1: write_region_base(32'd4293918720);
                2: write_region_base(32'($urandom_range(1, 1048320)) * SECTOR);
                3: write_region_base(32'($urandom_range(4096, 32'hFFF00000)));
                default: write_region_base(fdba_pkg::REGION_BASE_RST);
            endcase
            if (p == 2) begin
                fill_directory();
            end
            for (int i = 0; i < 140; i++) begin
                random_request();
            end
        end

        // Drain and report.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[flash_directory_bump_allocator_unit] OK");
        end else begin
            $display("[flash_directory_bump_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule
